// ===== hw/rtl/wmsi_pkg.sv =====
// wmsi_pkg: shared types and constants of the wheel motion safety interlock
// holds event codes, register indexes, flag and result structs
// no dependencies
package wmsi_pkg;

    // event codes carried in the action field
    typedef enum logic [2:0] {
        ACT_ACTIVATE = 3'd0,
        ACT_SENSOR   = 3'd1,
        ACT_LOAD     = 3'd2,
        ACT_MOVE     = 3'd3,
        ACT_TIMEOUT  = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic {
        REG_STALL_LOAD_THRESHOLD = 1'b0,
        REG_STALL_SAMPLE_LIMIT   = 1'b1
    } cfg_reg_t;

    localparam int unsigned LOAD_BITS  = 7;
    localparam int unsigned COUNT_BITS = 4;
    localparam int unsigned CFG_BITS   = 7;

    localparam logic [LOAD_BITS-1:0]  THRESHOLD_RESET = 7'd50;
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET     = 4'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX       = 4'd15;

    // contact_bits positions
    localparam int unsigned BIT_FRONT_L = 0;
    localparam int unsigned BIT_LIDAR_L = 1;
    localparam int unsigned BIT_FRONT_R = 2;
    localparam int unsigned BIT_LIDAR_R = 3;
    localparam int unsigned BIT_SIDE_L  = 4;
    localparam int unsigned BIT_SIDE_R  = 5;
    localparam int unsigned BIT_DROP_L  = 6;
    localparam int unsigned BIT_DROP_R  = 7;

    // interlock flags kept between events
    typedef struct packed {
        logic                  front_left;
        logic                  front_right;
        logic                  side_left;
        logic                  side_right;
        logic                  lifted;
        logic                  stall_front;
        logic                  stall_rear;
        logic                  moving;
        logic                  timeout;
        logic [COUNT_BITS-1:0] overload_count;
    } flags_t;

    // one result item
    typedef struct packed {
        logic move_allowed;
        logic stop_wheels;
        logic stop_motors;
        logic wheels_in_motion;
        logic front_left_blocked;
        logic front_right_blocked;
        logic side_left_hit;
        logic side_right_hit;
        logic lifted;
        logic front_stalled;
        logic rear_stalled;
        logic client_lost;
    } result_t;

    // handshake between the input register and the result register
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

// ===== hw/rtl/wmsi_in_stage.sv =====
// wmsi_in_stage: input register of the interlock with valid/ready handshake
// depends on wmsi_pkg
module wmsi_in_stage
    import wmsi_pkg::*;
#(
    parameter int unsigned DISTANCE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [2:0]                      action,
    input  logic [7:0]                      contact_bits,
    input  logic                            quiet_update,
    input  logic signed [DISTANCE_BITS-1:0] left_distance,
    input  logic signed [DISTANCE_BITS-1:0] right_distance,
    input  logic [LOAD_BITS-1:0]            left_load,
    input  logic [LOAD_BITS-1:0]            right_load,
    input  logic                            advance,
    output stage_ctrl_t                     ctrl,
    output logic [2:0]                      action_q,
    output logic [7:0]                      contact_bits_q,
    output logic                            quiet_update_q,
    output logic signed [DISTANCE_BITS-1:0] left_distance_q,
    output logic signed [DISTANCE_BITS-1:0] right_distance_q,
    output logic [LOAD_BITS-1:0]            left_load_q,
    output logic [LOAD_BITS-1:0]            right_load_q
);

    logic                            valid_reg;
    logic                            valid_next;
    logic                            load_en;
    logic [2:0]                      action_reg;
    logic [7:0]                      contact_reg;
    logic                            quiet_reg;
    logic signed [DISTANCE_BITS-1:0] left_dist_reg;
    logic signed [DISTANCE_BITS-1:0] right_dist_reg;
    logic [LOAD_BITS-1:0]            left_load_reg;
    logic [LOAD_BITS-1:0]            right_load_reg;

    // slot frees when its item moves on
    assign item_ready = !valid_reg || advance;
    assign load_en    = item_valid && item_ready;
    assign valid_next = load_en ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            action_reg     <= action;
            contact_reg    <= contact_bits;
            quiet_reg      <= quiet_update;
            left_dist_reg  <= left_distance;
            right_dist_reg <= right_distance;
            left_load_reg  <= left_load;
            right_load_reg <= right_load;
        end
    end

    assign ctrl.valid       = valid_reg;
    assign ctrl.advance     = advance;
    assign action_q         = action_reg;
    assign contact_bits_q   = contact_reg;
    assign quiet_update_q   = quiet_reg;
    assign left_distance_q  = left_dist_reg;
    assign right_distance_q = right_dist_reg;
    assign left_load_q      = left_load_reg;
    assign right_load_q     = right_load_reg;

endmodule

// ===== hw/rtl/wmsi_step.sv =====
// wmsi_step: combinational event evaluation, flags and last commands in, next state and result out
// depends on wmsi_pkg
module wmsi_step
    import wmsi_pkg::*;
#(
    parameter int unsigned DISTANCE_BITS = 16
) (
    input  flags_t                          flags,
    input  logic signed [DISTANCE_BITS-1:0] last_left,
    input  logic signed [DISTANCE_BITS-1:0] last_right,
    input  logic [LOAD_BITS-1:0]            threshold,
    input  logic [COUNT_BITS-1:0]           sample_limit,
    input  logic [2:0]                      action,
    input  logic [7:0]                      contact_bits,
    input  logic                            quiet_update,
    input  logic signed [DISTANCE_BITS-1:0] left_distance,
    input  logic signed [DISTANCE_BITS-1:0] right_distance,
    input  logic [LOAD_BITS-1:0]            left_load,
    input  logic [LOAD_BITS-1:0]            right_load,
    output flags_t                          flags_next,
    output logic signed [DISTANCE_BITS-1:0] last_left_next,
    output logic signed [DISTANCE_BITS-1:0] last_right_next,
    output result_t                         result
);

    // sensor sample decode
    logic nb_fl, nb_fr, nb_sl, nb_sr, nb_lift;
    logic lift_rise, bump_rise, sensor_stop;

    // load sample
    logic                  last_l_nz, last_r_nz;
    logic                  over;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  stall_hit;
    logic                  stall_fwd, stall_back;

    // move request
    logic l_nz, r_nz, l_neg, r_neg, l_pos, r_pos;
    logic nonzero, fwd, back, tleft, tright;
    logic front_blk, rear_blk;
    logic judge_ok;

    logic allowed, stopw, stopm;

    assign nb_fl   = contact_bits[BIT_FRONT_L] || contact_bits[BIT_LIDAR_L];
    assign nb_fr   = contact_bits[BIT_FRONT_R] || contact_bits[BIT_LIDAR_R];
    assign nb_sl   = contact_bits[BIT_SIDE_L];
    assign nb_sr   = contact_bits[BIT_SIDE_R];
    assign nb_lift = contact_bits[BIT_DROP_L] || contact_bits[BIT_DROP_R];

    assign lift_rise   = nb_lift && !flags.lifted;
    assign bump_rise   = (nb_fl && !flags.front_left) || (nb_fr && !flags.front_right)
                       || (nb_sl && !flags.side_left) || (nb_sr && !flags.side_right);
    assign sensor_stop = !quiet_update && (lift_rise || bump_rise);

    assign last_l_nz = last_left != '0;
    assign last_r_nz = last_right != '0;
    assign over      = (last_l_nz && left_load >= threshold)
                     || (last_r_nz && right_load >= threshold);
    assign count_inc = (flags.overload_count < COUNT_MAX) ? flags.overload_count + 1'b1
                                                          : flags.overload_count;
    assign stall_hit = count_inc >= sample_limit;
    assign stall_fwd  = (last_l_nz && !last_left[DISTANCE_BITS-1])
                      || (last_r_nz && !last_right[DISTANCE_BITS-1]);
    assign stall_back = last_left[DISTANCE_BITS-1] || last_right[DISTANCE_BITS-1];

    assign l_nz    = left_distance != '0;
    assign r_nz    = right_distance != '0;
    assign l_neg   = left_distance[DISTANCE_BITS-1];
    assign r_neg   = right_distance[DISTANCE_BITS-1];
    assign l_pos   = l_nz && !l_neg;
    assign r_pos   = r_nz && !r_neg;
    assign nonzero = l_nz || r_nz;
    assign fwd     = l_pos || r_pos;
    assign back    = l_neg || r_neg;
    assign tleft   = right_distance > left_distance;
    assign tright  = left_distance > right_distance;

    // blocking uses the stall latches as they stood before the escape clears
    assign front_blk = flags.front_left || flags.front_right || flags.stall_front;
    assign rear_blk  = flags.stall_rear;
    assign judge_ok  = !flags.lifted
                     && !(front_blk && fwd)
                     && !(!back && ((flags.front_left && tright) || (flags.front_right && tleft)))
                     && !(rear_blk && back)
                     && !(!back && ((flags.side_left && tright) || (flags.side_right && tleft)));

    always_comb
    begin
        flags_next      = flags;
        last_left_next  = last_left;
        last_right_next = last_right;
        allowed         = 1'b0;
        stopw           = 1'b0;
        stopm           = 1'b0;
        unique case (action_t'(action))
            ACT_ACTIVATE:
            begin
                flags_next = '0;
            end
            ACT_SENSOR:
            begin
                flags_next.front_left  = nb_fl;
                flags_next.front_right = nb_fr;
                flags_next.side_left   = nb_sl;
                flags_next.side_right  = nb_sr;
                flags_next.lifted      = nb_lift;
                stopw                  = sensor_stop;
                stopm                  = !quiet_update && lift_rise;
                if (sensor_stop)
                begin
                    flags_next.moving = 1'b0;
                end
            end
            ACT_LOAD:
            begin
                if (flags.moving)
                begin
                    if (!over)
                    begin
                        flags_next.overload_count = '0;
                    end
                    else
                    begin
                        flags_next.overload_count = count_inc;
                        if (stall_hit)
                        begin
                            flags_next.stall_front = flags.stall_front || stall_fwd;
                            flags_next.stall_rear  = flags.stall_rear || stall_back;
                            flags_next.moving      = 1'b0;
                            stopw                  = 1'b1;
                        end
                    end
                end
            end
            ACT_MOVE:
            begin
                if (!nonzero)
                begin
                    flags_next.moving = 1'b0;
                    allowed           = 1'b1;
                end
                else if (!flags.timeout)
                begin
                    // escape direction clears the opposite stall latch
                    if (!flags.lifted && back && !fwd)
                    begin
                        flags_next.stall_front = 1'b0;
                    end
                    if (!flags.lifted && fwd && !back)
                    begin
                        flags_next.stall_rear = 1'b0;
                    end
                    if (!judge_ok)
                    begin
                        flags_next.moving = 1'b0;
                        stopw             = 1'b1;
                    end
                    else
                    begin
                        last_left_next  = left_distance;
                        last_right_next = right_distance;
                        allowed         = 1'b1;
                        if (!flags.moving)
                        begin
                            flags_next.moving         = 1'b1;
                            flags_next.overload_count = '0;
                        end
                    end
                end
            end
            ACT_TIMEOUT:
            begin
                if (!flags.timeout)
                begin
                    flags_next.moving  = 1'b0;
                    flags_next.timeout = 1'b1;
                    stopw              = 1'b1;
                end
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

    assign result.move_allowed        = allowed;
    assign result.stop_wheels         = stopw;
    assign result.stop_motors         = stopm;
    assign result.wheels_in_motion    = flags_next.moving;
    assign result.front_left_blocked  = flags_next.front_left;
    assign result.front_right_blocked = flags_next.front_right;
    assign result.side_left_hit       = flags_next.side_left;
    assign result.side_right_hit      = flags_next.side_right;
    assign result.lifted              = flags_next.lifted;
    assign result.front_stalled       = flags_next.stall_front;
    assign result.rear_stalled        = flags_next.stall_rear;
    assign result.client_lost         = flags_next.timeout;

endmodule

// ===== hw/rtl/wmsi_out_stage.sv =====
// wmsi_out_stage: result register with valid/ready handshake
// depends on wmsi_pkg
module wmsi_out_stage
    import wmsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pending,
    input  result_t result_next,
    output logic    advance,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // register takes a new result when empty or when its result leaves now
    assign advance    = pending && (!valid_reg || result_ready);
    assign valid_next = advance ? 1'b1 : (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/wheel_motion_safety_interlock_top.sv =====
// wheel_motion_safety_interlock_top: safety interlock for a two-wheel robot
// depends on wmsi_pkg, wmsi_in_stage, wmsi_step, wmsi_out_stage
//
// channel   direction  handshake                   payload
// item      in         item_valid / item_ready     action, contact_bits, quiet_update,
//                                                  left_distance, right_distance,
//                                                  left_load, right_load
// result    out        result_valid / result_ready move_allowed, stop_wheels, stop_motors,
//                                                  nine flag outputs
// config    in         cfg_write_en (no wait)      cfg_index, cfg_data
//
// one item per cycle sustained while result_ready is high; each item passes the input
// register, then the event logic into the result register, from which its result
// is offered
// the event logic is a single shallow pass over the flags, so each item sees the
// state left by the one before it with no bubble
// reset clears all flags, the overload counter, the last commands and both registers
// to their defaults (threshold 50, sample limit 3); no clearing pass
// a stalled result holds the input register, which then holds item_ready low
module wheel_motion_safety_interlock_top
    import wmsi_pkg::*;
#(
    parameter int unsigned DISTANCE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // item channel
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [2:0]                      action,
    input  logic [7:0]                      contact_bits,
    input  logic                            quiet_update,
    input  logic signed [DISTANCE_BITS-1:0] left_distance,
    input  logic signed [DISTANCE_BITS-1:0] right_distance,
    input  logic [LOAD_BITS-1:0]            left_load,
    input  logic [LOAD_BITS-1:0]            right_load,
    // result channel
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic                            move_allowed,
    output logic                            stop_wheels,
    output logic                            stop_motors,
    output logic                            wheels_in_motion,
    output logic                            front_left_blocked,
    output logic                            front_right_blocked,
    output logic                            side_left_hit,
    output logic                            side_right_hit,
    output logic                            lifted,
    output logic                            front_stalled,
    output logic                            rear_stalled,
    output logic                            client_lost,
    // configuration write port
    input  logic                            cfg_write_en,
    input  logic                            cfg_index,
    input  logic [CFG_BITS-1:0]             cfg_data
);

    // configuration registers
    logic [LOAD_BITS-1:0]  threshold_reg;
    logic [COUNT_BITS-1:0] limit_reg;

    // interlock state
    flags_t                          flags_reg;
    flags_t                          flags_next;
    logic signed [DISTANCE_BITS-1:0] last_left_reg;
    logic signed [DISTANCE_BITS-1:0] last_left_next;
    logic signed [DISTANCE_BITS-1:0] last_right_reg;
    logic signed [DISTANCE_BITS-1:0] last_right_next;

    // registered item
    stage_ctrl_t                     in_ctrl;
    logic                            advance;
    logic [2:0]                      action_q;
    logic [7:0]                      contact_q;
    logic                            quiet_q;
    logic signed [DISTANCE_BITS-1:0] left_dist_q;
    logic signed [DISTANCE_BITS-1:0] right_dist_q;
    logic [LOAD_BITS-1:0]            left_load_q;
    logic [LOAD_BITS-1:0]            right_load_q;

    result_t result_next;
    result_t result_q;

    // config writes must be made only while idle, not enforced here; no ordering against items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STALL_LOAD_THRESHOLD: threshold_reg <= cfg_data[LOAD_BITS-1:0];
                REG_STALL_SAMPLE_LIMIT:   limit_reg     <= cfg_data[COUNT_BITS-1:0];
            endcase
        end
    end

    wmsi_in_stage #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_in_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .action           (action),
        .contact_bits     (contact_bits),
        .quiet_update     (quiet_update),
        .left_distance    (left_distance),
        .right_distance   (right_distance),
        .left_load        (left_load),
        .right_load       (right_load),
        .advance          (advance),
        .ctrl             (in_ctrl),
        .action_q         (action_q),
        .contact_bits_q   (contact_q),
        .quiet_update_q   (quiet_q),
        .left_distance_q  (left_dist_q),
        .right_distance_q (right_dist_q),
        .left_load_q      (left_load_q),
        .right_load_q     (right_load_q)
    );

    wmsi_step #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_step (
        .flags           (flags_reg),
        .last_left       (last_left_reg),
        .last_right      (last_right_reg),
        .threshold       (threshold_reg),
        .sample_limit    (limit_reg),
        .action          (action_q),
        .contact_bits    (contact_q),
        .quiet_update    (quiet_q),
        .left_distance   (left_dist_q),
        .right_distance  (right_dist_q),
        .left_load       (left_load_q),
        .right_load      (right_load_q),
        .flags_next      (flags_next),
        .last_left_next  (last_left_next),
        .last_right_next (last_right_next),
        .result          (result_next)
    );

    // state commits in the same cycle that the result is captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= '0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end
        else if (in_ctrl.advance)
        begin
            flags_reg      <= flags_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
        end
    end

    wmsi_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .pending      (in_ctrl.valid),
        .result_next  (result_next),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_q)
    );

    assign move_allowed        = result_q.move_allowed;
    assign stop_wheels         = result_q.stop_wheels;
    assign stop_motors         = result_q.stop_motors;
    assign wheels_in_motion    = result_q.wheels_in_motion;
    assign front_left_blocked  = result_q.front_left_blocked;
    assign front_right_blocked = result_q.front_right_blocked;
    assign side_left_hit       = result_q.side_left_hit;
    assign side_right_hit      = result_q.side_right_hit;
    assign lifted              = result_q.lifted;
    assign front_stalled       = result_q.front_stalled;
    assign rear_stalled        = result_q.rear_stalled;
    assign client_lost         = result_q.client_lost;

endmodule
